// File: rtl/csx_pkg.sv
// Shared types and constants for the CAN signal extract and scale block.
package csx_pkg;

    localparam int DATA_W          = 64;
    localparam int BYTE_W          = 8;
    localparam int MAX_BYTES       = 8;
    localparam int SLOT_W          = 4;
    localparam int GAIN_W          = 32;
    localparam int CNT_W           = 4;
    localparam int FRAME_BYTES_DEF = 8;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MAP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MAP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_SIGNED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_MODE = 3'd6;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;

    // What one byte lane contributes to the value word and the constraint word.
    typedef struct packed {
        logic [DATA_W-1:0] val_word;
        logic              val_sel;
        logic [DATA_W-1:0] mat_word;
    } csx_lane_t;

    // Per-request control carried down the pipeline.
    typedef struct packed {
        logic valid;
        logic emit;
        logic hit;
    } csx_ctl_t;

endpackage

// File: rtl/can_signal_extract_scale.sv
// Top level of the CAN signal extract and scale block.
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ------------------------------------
//  request   in         start, busy                byte0 .. byte7
//  result    out        done (one-cycle strobe)    emitted, scaled_value, event_hit,
//                                                  length_error, saturated
//  config    in         cfg_valid, cfg_ready       cfg_index, cfg_data
//
//  One request per clock is accepted; busy stays low. Every request yields one
//  result, passing in order through lane merge, raw extraction, 32x32 partial products,
//  product sign fix, offset and clamp, one register stage each. The two partial
//  products of the 64x32 multiply set the stage split. Reset is asynchronous and
//  active low; it clears the pipeline valids and loads the register defaults.
//  The receiver cannot stall, so nothing ever backs up.
module can_signal_extract_scale
    import csx_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [7:0]           byte0,
    input  logic [7:0]           byte1,
    input  logic [7:0]           byte2,
    input  logic [7:0]           byte3,
    input  logic [7:0]           byte4,
    input  logic [7:0]           byte5,
    input  logic [7:0]           byte6,
    input  logic [7:0]           byte7,
    output logic                 done,
    output logic                 emitted,
    output logic signed [63:0]   scaled_value,
    output logic                 event_hit,
    output logic                 length_error,
    output logic                 saturated,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    logic [31:0]       value_map_reg;
    logic [31:0]       match_map_reg;
    logic [63:0]       pattern_reg;
    logic              pattern_single_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [63:0]       offset_reg;
    logic              raw_signed_reg;
    logic              event_mode_reg;

    logic              cfg_write;
    logic              accept;
    logic [BYTE_W-1:0] frame [MAX_BYTES];
    csx_lane_t         lanes [MAX_BYTES];
    csx_ctl_t          merge_ctl;
    logic [DATA_W-1:0] merge_word;
    logic [CNT_W-1:0]  merge_cnt;
    logic [DATA_W-1:0] value_out;

    // The pipeline takes a request every cycle, and config is always taken.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = start && !busy;

    // Register file. Precompute the single-bit test of the pattern on write
    // so the merge stage only has a compare to do.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_map_reg      <= '0;
            match_map_reg      <= '0;
            pattern_reg        <= '0;
            pattern_single_reg <= 1'b0;
            gain_reg           <= GAIN_RESET;
            offset_reg         <= '0;
            raw_signed_reg     <= 1'b0;
            event_mode_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_VALUE_MAP:  value_map_reg <= cfg_data[31:0];
                CFG_MATCH_MAP:  match_map_reg <= cfg_data[31:0];
                CFG_PATTERN:
                begin
                    pattern_reg        <= cfg_data;
                    pattern_single_reg <= (cfg_data != '0) &&
                                          ((cfg_data & (cfg_data - 64'd1)) == '0);
                end
                CFG_GAIN:       gain_reg       <= cfg_data[GAIN_W-1:0];
                CFG_OFFSET:     offset_reg     <= cfg_data;
                CFG_RAW_SIGNED: raw_signed_reg <= cfg_data[0];
                CFG_EVENT_MODE: event_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign frame[0] = byte0;
    assign frame[1] = byte1;
    assign frame[2] = byte2;
    assign frame[3] = byte3;
    assign frame[4] = byte4;
    assign frame[5] = byte5;
    assign frame[6] = byte6;
    assign frame[7] = byte7;

    // One lane per data byte; lanes past the frame length drop their byte.
    for (genvar j = 0; j < MAX_BYTES; j++)
    begin : g_lane
        csx_lane #(
            .LANE_ON (j < FRAME_BYTES)
        ) u_lane (
            .data_byte (frame[j]),
            .val_slot  (value_map_reg[SLOT_W*j +: SLOT_W]),
            .mat_slot  (match_map_reg[SLOT_W*j +: SLOT_W]),
            .lane      (lanes[j])
        );
    end

    csx_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .lanes          (lanes),
        .event_mode     (event_mode_reg),
        .pattern        (pattern_reg),
        .pattern_single (pattern_single_reg),
        .ctl            (merge_ctl),
        .word           (merge_word),
        .cnt            (merge_cnt)
    );

    csx_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (merge_ctl),
        .word         (merge_word),
        .cnt          (merge_cnt),
        .raw_signed   (raw_signed_reg),
        .gain         (gain_reg),
        .offset       (offset_reg),
        .done         (done),
        .emitted      (emitted),
        .scaled_value (value_out),
        .event_hit    (event_hit),
        .length_error (length_error),
        .saturated    (saturated)
    );

    assign scaled_value = value_out;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("accepted request did not produce a result on time");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("result strobe without a matching request");

    a_quiet_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done && !emitted |-> (value_out == '0) && !event_hit && !length_error && !saturated)
        else $error("dropped frame carries nonzero fields");

    a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
        done && length_error |-> (value_out == '0) && !saturated)
        else $error("length error with a value or a clamp");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> (value_out == 64'h8000_0000_0000_0000) ||
                              (value_out == 64'h7FFF_FFFF_FFFF_FFFF))
        else $error("clamped value is not a range limit");
`endif

endmodule

// File: rtl/csx_lane.sv
// One byte lane: places a data byte by its value slot and its match slot.
module csx_lane
    import csx_pkg::*;
#(
    parameter bit LANE_ON = 1'b1
)
(
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [SLOT_W-1:0] val_slot,
    input  logic [SLOT_W-1:0] mat_slot,
    output csx_lane_t         lane
);

    logic       val_hit;
    logic       mat_hit;
    logic [2:0] val_pos;
    logic [2:0] mat_pos;

    // slot 1..8 maps to byte position 0..7; anything else leaves the byte out
    assign val_hit = LANE_ON && (val_slot != '0) && (val_slot <= SLOT_W'(MAX_BYTES));
    assign mat_hit = LANE_ON && (mat_slot != '0) && (mat_slot <= SLOT_W'(MAX_BYTES));
    assign val_pos = val_slot[2:0] - 3'd1;
    assign mat_pos = mat_slot[2:0] - 3'd1;

    always_comb
    begin
        lane.val_sel  = val_hit;
        lane.val_word = val_hit ? ({{(DATA_W-BYTE_W){1'b0}}, data_byte} << {val_pos, 3'b000})
                                : '0;
        lane.mat_word = mat_hit ? ({{(DATA_W-BYTE_W){1'b0}}, data_byte} << {mat_pos, 3'b000})
                                : '0;
    end

endmodule

// File: rtl/csx_merge.sv
// Merge stage: ORs lane words, counts selected bytes and tests the event pattern.
module csx_merge
    import csx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  csx_lane_t         lanes [MAX_BYTES],
    input  logic              event_mode,
    input  logic [DATA_W-1:0] pattern,
    input  logic              pattern_single,
    output csx_ctl_t          ctl,
    output logic [DATA_W-1:0] word,
    output logic [CNT_W-1:0]  cnt
);

    logic [DATA_W-1:0] val_or;
    logic [DATA_W-1:0] mat_or;
    logic [CNT_W-1:0]  sel_cnt;
    logic              match;
    csx_ctl_t          ctl_reg;
    csx_ctl_t          ctl_next;
    logic [DATA_W-1:0] word_reg;
    logic [CNT_W-1:0]  cnt_reg;

    always_comb
    begin
        val_or  = '0;
        mat_or  = '0;
        sel_cnt = '0;
        for (int j = 0; j < MAX_BYTES; j++)
        begin
            val_or  = val_or | lanes[j].val_word;
            mat_or  = mat_or | lanes[j].mat_word;
            sel_cnt = sel_cnt + CNT_W'(lanes[j].val_sel);
        end
        match = pattern_single ? ((mat_or & pattern) == pattern) : (mat_or == pattern);
        ctl_next.valid = accept;
        ctl_next.emit  = !event_mode || match;
        ctl_next.hit   = event_mode && match;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= val_or;
        cnt_reg  <= sel_cnt;
    end

    assign ctl  = ctl_reg;
    assign word = word_reg;
    assign cnt  = cnt_reg;

endmodule

// File: rtl/csx_scale.sv
// Scaling pipeline: raw extraction, split multiply, offset and saturation.
module csx_scale
    import csx_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  csx_ctl_t                 ctl,
    input  logic [DATA_W-1:0]        word,
    input  logic [CNT_W-1:0]         cnt,
    input  logic                     raw_signed,
    input  logic [GAIN_W-1:0]        gain,
    input  logic [DATA_W-1:0]        offset,
    output logic                     done,
    output logic                     emitted,
    output logic [DATA_W-1:0]        scaled_value,
    output logic                     event_hit,
    output logic                     length_error,
    output logic                     saturated
);

    localparam int PROD_W = DATA_W + GAIN_W;

    // stage 2: raw value and magnitudes
    logic [DATA_W-1:0] mask;
    logic              sign_bit;
    logic              len_ok;
    logic              rneg;
    logic [DATA_W-1:0] raw;
    logic [DATA_W-1:0] mag_next;
    logic [GAIN_W-1:0] gmag_next;
    csx_ctl_t          ctl2_reg;
    logic              lerr2_reg;
    logic              neg2_reg;
    logic [DATA_W-1:0] mag_reg;
    logic [GAIN_W-1:0] gmag_reg;

    // stage 3: partial products
    csx_ctl_t          ctl3_reg;
    logic              lerr3_reg;
    logic              neg3_reg;
    logic [DATA_W-1:0] p0_reg;
    logic [DATA_W-1:0] p1_reg;

    // stage 4: signed product
    logic [PROD_W-1:0] prod;
    logic [PROD_W:0]   sprod_next;
    csx_ctl_t          ctl4_reg;
    logic              lerr4_reg;
    logic [PROD_W:0]   sprod_reg;

    // stage 5: offset and clamp
    logic [PROD_W+1:0] diff;
    logic              fits;
    logic              done_reg;
    logic              emit_reg;
    logic              hit_reg;
    logic              lerr_reg;
    logic              sat_reg;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              sat_next;

    always_comb
    begin
        len_ok = 1'b1;
        case (cnt)
            4'd1:
            begin
                mask     = 64'h0000_0000_0000_00FF;
                sign_bit = word[7];
            end
            4'd2:
            begin
                mask     = 64'h0000_0000_0000_FFFF;
                sign_bit = word[15];
            end
            4'd4:
            begin
                mask     = 64'h0000_0000_FFFF_FFFF;
                sign_bit = word[31];
            end
            4'd8:
            begin
                mask     = '1;
                sign_bit = word[63];
            end
            default:
            begin
                mask     = '0;
                sign_bit = 1'b0;
                len_ok   = 1'b0;
            end
        endcase
        raw       = word & mask;
        rneg      = raw_signed && sign_bit;
        mag_next  = rneg ? (~(raw | ~mask) + DATA_W'(1)) : raw;
        gmag_next = gain[GAIN_W-1] ? (~gain + GAIN_W'(1)) : gain;
    end

    always_comb
    begin
        prod = {{GAIN_W{1'b0}}, p0_reg} + {p1_reg, {GAIN_W{1'b0}}};
        sprod_next = neg3_reg ? (~{1'b0, prod} + (PROD_W+1)'(1)) : {1'b0, prod};
    end

    always_comb
    begin
        diff = {sprod_reg[PROD_W], sprod_reg}
             - {{(PROD_W+2-DATA_W){offset[DATA_W-1]}}, offset};
        fits = (&diff[PROD_W+1:DATA_W-1]) || !(|diff[PROD_W+1:DATA_W-1]);
        if (!ctl4_reg.emit || lerr4_reg)
        begin
            value_next = '0;
            sat_next   = 1'b0;
        end
        else if (fits)
        begin
            value_next = diff[DATA_W-1:0];
            sat_next   = 1'b0;
        end
        else
        begin
            value_next = diff[PROD_W+1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
            sat_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl2_reg <= ctl;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            done_reg <= ctl4_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        lerr2_reg <= ctl.emit && !len_ok;
        neg2_reg  <= rneg ^ gain[GAIN_W-1];
        mag_reg   <= mag_next;
        gmag_reg  <= gmag_next;

        lerr3_reg <= lerr2_reg;
        neg3_reg  <= neg2_reg;
        p0_reg    <= DATA_W'(mag_reg[31:0]) * DATA_W'(gmag_reg);
        p1_reg    <= DATA_W'(mag_reg[63:32]) * DATA_W'(gmag_reg);

        lerr4_reg <= lerr3_reg;
        sprod_reg <= sprod_next;

        emit_reg  <= ctl4_reg.emit;
        hit_reg   <= ctl4_reg.emit && ctl4_reg.hit;
        lerr_reg  <= lerr4_reg;
        sat_reg   <= sat_next;
        value_reg <= value_next;
    end

    assign done         = done_reg;
    assign emitted      = emit_reg;
    assign scaled_value = value_reg;
    assign event_hit    = hit_reg;
    assign length_error = lerr_reg;
    assign saturated    = sat_reg;

endmodule
